// ===== hdl/uf2bwt_pkg.sv =====
package uf2bwt_pkg;

  // Tracker sizing
  localparam int unsigned MAX_BLOCKS   = 2048;
  localparam int unsigned BLOCK_BYTES  = 256;
  localparam int unsigned BNUM_W       = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W        = BNUM_W + 1;
  localparam int unsigned ROW_W        = 8;
  localparam int unsigned BIT_W        = $clog2(ROW_W);
  localparam int unsigned ROWS         = MAX_BLOCKS / ROW_W;
  localparam int unsigned ROW_AW       = $clog2(ROWS);
  localparam int unsigned PAY_AW       = $clog2(BLOCK_BYTES);

  localparam logic [31:0] TOTAL_LOCKED = 32'hffff_ffff;

  // Stream widths
  localparam int unsigned IN_W   = 9 * 32;
  localparam int unsigned OUT_RW = 2 + 1 + 32 + 1;
  localparam int unsigned OUT_W  = ((OUT_RW + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CFG_AW = 3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FAMILY_CODE      = 3'd0,
    CFG_FLASH_START      = 3'd1,
    CFG_FLASH_SIZE       = 3'd2,
    CFG_MAGIC_FIRST      = 3'd3,
    CFG_MAGIC_SECOND     = 3'd4,
    CFG_MAGIC_FINAL      = 3'd5,
    CFG_NOFLASH_MASK     = 3'd6,
    CFG_FAMILY_FLAG_MASK = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_BAD_MAGIC    = 2'd0,
    ST_WRONG_FAMILY = 2'd1,
    ST_BAD_TARGET   = 2'd2,
    ST_WRITTEN      = 2'd3
  } status_e;

  // Header word, start_word_a in the lowest bits
  typedef struct packed {
    logic [31:0] end_word;
    logic [31:0] block_family;
    logic [31:0] total_blocks;
    logic [31:0] block_number;
    logic [31:0] payload_bytes;
    logic [31:0] target_address;
    logic [31:0] block_flags;
    logic [31:0] start_word_b;
    logic [31:0] start_word_a;
  } hdr_t;

  typedef struct packed {
    logic [31:0] family_code;
    logic [31:0] flash_start;
    logic [31:0] flash_size;
    logic [31:0] magic_first;
    logic [31:0] magic_second;
    logic [31:0] magic_final;
    logic [31:0] noflash_mask;
    logic [31:0] family_flag_mask;
  } cfg_t;

  // Header check result
  typedef struct packed {
    status_e status;
    logic    counts;    // accepted block with nonzero total
    logic    in_range;  // block number below MAX_BLOCKS
    logic    big_total; // total at or above MAX_BLOCKS
  } chk_t;

endpackage

// ===== hdl/uf2bwt_check.sv =====
module uf2bwt_check (
  input  uf2bwt_pkg::hdr_t hdr_i,
  input  uf2bwt_pkg::cfg_t cfg_i,
  output uf2bwt_pkg::chk_t chk_o
);

  logic magic_ok;
  logic family_ok;
  logic target_bad;

  // Magic and family checks
  assign magic_ok  = (hdr_i.start_word_a == cfg_i.magic_first) &&
                     (hdr_i.start_word_b == cfg_i.magic_second) &&
                     (hdr_i.end_word == cfg_i.magic_final);
  assign family_ok = ((hdr_i.block_flags & cfg_i.family_flag_mask) != 32'd0) &&
                     (hdr_i.block_family == cfg_i.family_code);

  // Target checks
  assign target_bad =
      ((hdr_i.block_flags & cfg_i.noflash_mask) != 32'd0) ||
      (hdr_i.payload_bytes != 32'(uf2bwt_pkg::BLOCK_BYTES)) ||
      (hdr_i.target_address[uf2bwt_pkg::PAY_AW-1:0] != '0) ||
      (hdr_i.target_address < cfg_i.flash_start) ||
      (hdr_i.target_address >= cfg_i.flash_size);

  always_comb begin
    if (!magic_ok) begin
      chk_o.status = uf2bwt_pkg::ST_BAD_MAGIC;
    end else if (!family_ok) begin
      chk_o.status = uf2bwt_pkg::ST_WRONG_FAMILY;
    end else if (target_bad) begin
      chk_o.status = uf2bwt_pkg::ST_BAD_TARGET;
    end else begin
      chk_o.status = uf2bwt_pkg::ST_WRITTEN;
    end
    chk_o.counts    = magic_ok && family_ok && (hdr_i.total_blocks != 32'd0);
    chk_o.in_range  = (hdr_i.block_number[31:uf2bwt_pkg::BNUM_W] == '0);
    chk_o.big_total = (hdr_i.total_blocks[31:uf2bwt_pkg::BNUM_W] != '0);
  end

endmodule

// ===== hdl/uf2_block_write_tracker_top.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   288    header word: start_word_a .. end_word, 32 bits each
// m_axis    out  40     block_status, flash_write, flash_address, all_done
// cfg       in   3+32   register index and write data, no read-back
//
// One header word per cycle, sustained while the output is taken; the header is
// checked as its word is taken, and its result word goes through the update stage
// (bitmap read-modify-write) and then the output register.
// Rate is set by the seen-block bitmap memory: one read at accept, one write
// as the word leaves the update stage, with forwarding between neighbors.
// Reset clears the per-row valid bits at once, so no clearing pass is needed.
// A stalled output holds one result while one more word waits in the update stage.
module uf2_block_write_tracker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // start_word_a, start_word_b, block_flags, target_address, payload_bytes,
  // block_number, total_blocks, block_family, end_word (32 bits each)
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [uf2bwt_pkg::IN_W-1:0]   s_axis_tdata,
  // block_status[1:0], flash_write[2], flash_address[34:3], all_done[35]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [uf2bwt_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [uf2bwt_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned RowAw = uf2bwt_pkg::ROW_AW;
  localparam int unsigned BitW  = uf2bwt_pkg::BIT_W;
  localparam int unsigned RowW  = uf2bwt_pkg::ROW_W;
  localparam int unsigned CntW  = uf2bwt_pkg::CNT_W;

  uf2bwt_pkg::hdr_t hdr;
  uf2bwt_pkg::cfg_t cfg_q;
  uf2bwt_pkg::chk_t chk;

  logic s_acc;
  logic s1_adv;
  logic [RowAw-1:0] in_row;

  // Update stage
  logic                    s1_v_q;
  uf2bwt_pkg::chk_t        s1_chk_q;
  logic [31:0]             s1_addr_q;
  logic [31:0]             s1_total_q;
  logic [RowAw-1:0]        s1_row_q;
  logic [BitW-1:0]         s1_bit_q;
  logic [RowW-1:0]         rd_data_q;
  logic                    rd_vld_q;
  logic                    fwd_hit_q;
  logic [RowW-1:0]         fwd_data_q;

  // Tracker state
  logic [31:0]             exp_q;
  logic [31:0]             exp_d;
  logic [CntW-1:0]         cnt_q;
  logic [CntW-1:0]         cnt_inc;
  logic [uf2bwt_pkg::ROWS-1:0] row_vld_q;
  logic [RowW-1:0]         map_mem [uf2bwt_pkg::ROWS];

  logic [RowW-1:0]         cur_row;
  logic [RowW-1:0]         new_row;
  logic                    bit_new;
  logic                    wr_en;
  logic                    done;
  logic                    flash_wr;

  // Output register
  logic                    out_v_q;
  logic [uf2bwt_pkg::OUT_W-1:0] out_data_q;

  assign hdr    = uf2bwt_pkg::hdr_t'(s_axis_tdata);
  assign in_row = hdr.block_number[uf2bwt_pkg::BNUM_W-1:BitW];

  uf2bwt_check u_check (
    .hdr_i (hdr),
    .cfg_i (cfg_q),
    .chk_o (chk)
  );

  // Handshake
  assign s1_adv        = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.family_code      <= 32'd0;
      cfg_q.flash_start      <= 32'd0;
      cfg_q.flash_size       <= 32'h0004_0000;
      cfg_q.magic_first      <= 32'h0A32_4655;
      cfg_q.magic_second     <= 32'h9E5D_5157;
      cfg_q.magic_final      <= 32'h0AB1_6F30;
      cfg_q.noflash_mask     <= 32'h0000_0001;
      cfg_q.family_flag_mask <= 32'h0000_2000;
    end else if (cfg_we_i) begin
      case (uf2bwt_pkg::cfg_idx_e'(cfg_idx_i))
        uf2bwt_pkg::CFG_FAMILY_CODE:      cfg_q.family_code      <= cfg_data_i;
        uf2bwt_pkg::CFG_FLASH_START:      cfg_q.flash_start      <= cfg_data_i;
        uf2bwt_pkg::CFG_FLASH_SIZE:       cfg_q.flash_size       <= cfg_data_i;
        uf2bwt_pkg::CFG_MAGIC_FIRST:      cfg_q.magic_first      <= cfg_data_i;
        uf2bwt_pkg::CFG_MAGIC_SECOND:     cfg_q.magic_second     <= cfg_data_i;
        uf2bwt_pkg::CFG_MAGIC_FINAL:      cfg_q.magic_final      <= cfg_data_i;
        uf2bwt_pkg::CFG_NOFLASH_MASK:     cfg_q.noflash_mask     <= cfg_data_i;
        uf2bwt_pkg::CFG_FAMILY_FLAG_MASK: cfg_q.family_flag_mask <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Update stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  // Update stage payload; forward the row written on this same edge
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_chk_q   <= chk;
      s1_addr_q  <= hdr.target_address;
      s1_total_q <= hdr.total_blocks;
      s1_row_q   <= in_row;
      s1_bit_q   <= hdr.block_number[BitW-1:0];
      rd_vld_q   <= row_vld_q[in_row];
      fwd_hit_q  <= wr_en && (s1_row_q == in_row);
      fwd_data_q <= new_row;
    end
  end

  // Bitmap memory, read at accept, written as the update stage retires
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      rd_data_q <= map_mem[in_row];
    end
    if (wr_en) begin
      map_mem[s1_row_q] <= new_row;
    end
  end

  // Row view with forwarding and valid bits
  always_comb begin
    if (fwd_hit_q) begin
      cur_row = fwd_data_q;
    end else if (rd_vld_q) begin
      cur_row = rd_data_q;
    end else begin
      cur_row = '0;
    end
    new_row           = cur_row;
    new_row[s1_bit_q] = 1'b1;
    bit_new           = s1_chk_q.in_range && !cur_row[s1_bit_q];
  end

  // Total latch and completion test
  always_comb begin
    exp_d = exp_q;
    if (s1_total_q != exp_q) begin
      if (s1_chk_q.big_total || (exp_q != 32'd0)) begin
        exp_d = uf2bwt_pkg::TOTAL_LOCKED;
      end else begin
        exp_d = s1_total_q;
      end
    end
    cnt_inc  = cnt_q + CntW'(1);
    wr_en    = s1_adv && s1_chk_q.counts && bit_new;
    done     = s1_chk_q.counts && bit_new && (32'(cnt_inc) >= exp_d);
    flash_wr = (s1_chk_q.status == uf2bwt_pkg::ST_WRITTEN);
  end

  // Tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q     <= 32'd0;
      cnt_q     <= '0;
      row_vld_q <= '0;
    end else begin
      if (s1_adv && s1_chk_q.counts) begin
        exp_q <= exp_d;
      end
      if (wr_en) begin
        cnt_q               <= cnt_inc;
        row_vld_q[s1_row_q] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= uf2bwt_pkg::OUT_W'({done,
                                        (flash_wr ? s1_addr_q : 32'd0),
                                        flash_wr,
                                        s1_chk_q.status});
    end
  end

endmodule

// ===== hdl/uf2bwt_checker.sv =====
module uf2bwt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [uf2bwt_pkg::OUT_W-1:0]  m_axis_tdata
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Flash strobe exactly for written blocks
  a_flash_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] == uf2bwt_pkg::ST_WRITTEN)))
    else $error("flash_write does not match status");

  // No address without a strobe, and written addresses are page aligned
  a_flash_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2] ? (m_axis_tdata[10:3] == 8'd0)
                                      : (m_axis_tdata[34:3] == 32'd0)))
    else $error("flash_address inconsistent with flash_write");

  // Completion only from an accepted block
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[35] |->
      (m_axis_tdata[1:0] == uf2bwt_pkg::ST_BAD_TARGET) ||
      (m_axis_tdata[1:0] == uf2bwt_pkg::ST_WRITTEN))
    else $error("all_done on a rejected block");

endmodule

bind uf2_block_write_tracker_top uf2bwt_checker u_uf2bwt_checker (.*);
